/* design/deq_pkg.sv */
// shared types and constants for the double-ended queue
// no dependencies; imported by deq_ctrl, the top level and the testbench
package deq_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned OCC_W          = 7;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } deq_func_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } deq_status_e;

  typedef struct packed {
    deq_func_e                  func;
    logic signed [VALUE_W-1:0]  value;
  } deq_req_t;

  typedef struct packed {
    deq_status_e                status;
    logic signed [VALUE_W-1:0]  popped_value;
    logic [OCC_W-1:0]           occupancy;
  } deq_rsp_t;

  // registered result control handed from the pointer logic to the top level
  typedef struct packed {
    logic              valid;
    deq_status_e       status;
    logic              pop_ok;
    logic [OCC_W-1:0]  occupancy;
  } deq_rsp_ctl_t;

endpackage

/* design/deq_mem.sv */
// entry store: single-port synchronous ram with registered read data
// does not depend on deq_pkg
module deq_mem #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned ADDR_W    = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     addr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/deq_ctrl.sv */
// front/back pointers, entry count and memory request generation
// depends on deq_pkg for request and result-control types
module deq_ctrl #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned ADDR_W    = $clog2(DEPTH),
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  deq_pkg::deq_req_t       req_i,
  output logic                    mem_we_o,
  output logic                    mem_re_o,
  output logic [ADDR_W-1:0]       mem_addr_o,
  output logic [DATA_WIDTH-1:0]   mem_wdata_o,
  output deq_pkg::deq_rsp_ctl_t   rsp_ctl_o
);
  import deq_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

  logic [ADDR_W-1:0] front_q, front_d;
  logic [ADDR_W-1:0] back_q, back_d;
  logic [CNT_W-1:0]  count_q, count_d;
  deq_rsp_ctl_t      rsp_q, rsp_d;

  logic [ADDR_W-1:0] front_next, front_prev, back_next, back_prev;
  logic              is_full, is_empty;
  logic [63:0]       value_ext;
  logic [15:0]       occ_ext;
  deq_status_e       status;
  logic              pop_ok;

  assign front_next = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
  assign front_prev = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
  assign back_next  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;
  assign back_prev  = (back_q == '0) ? LAST_IDX : back_q - 1'b1;

  assign is_full  = (count_q == FULL_CNT);
  assign is_empty = (count_q == '0);

  // only the low DATA_WIDTH bits of a pushed value are kept
  assign value_ext   = 64'(unsigned'(req_i.value));
  assign mem_wdata_o = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    front_d    = front_q;
    back_d     = back_q;
    count_d    = count_q;
    mem_we_o   = 1'b0;
    mem_re_o   = 1'b0;
    mem_addr_o = front_q;
    status     = STATUS_DONE;
    pop_ok     = 1'b0;
    if (start_i) begin
      unique case (req_i.func)
        FUNC_PUSH_FRONT: begin
          if (is_full) begin
            status = STATUS_FULL;
          end else begin
            front_d    = front_prev;
            mem_addr_o = front_prev;
            mem_we_o   = 1'b1;
            count_d    = count_q + 1'b1;
          end
        end
        FUNC_PUSH_BACK: begin
          if (is_full) begin
            status = STATUS_FULL;
          end else begin
            mem_addr_o = back_q;
            back_d     = back_next;
            mem_we_o   = 1'b1;
            count_d    = count_q + 1'b1;
          end
        end
        FUNC_POP_FRONT: begin
          if (is_empty) begin
            status = STATUS_EMPTY;
          end else begin
            mem_addr_o = front_q;
            front_d    = front_next;
            mem_re_o   = 1'b1;
            pop_ok     = 1'b1;
            count_d    = count_q - 1'b1;
          end
        end
        FUNC_POP_BACK: begin
          if (is_empty) begin
            status = STATUS_EMPTY;
          end else begin
            mem_addr_o = back_prev;
            back_d     = back_prev;
            mem_re_o   = 1'b1;
            pop_ok     = 1'b1;
            count_d    = count_q - 1'b1;
          end
        end
      endcase
    end
  end

  assign occ_ext = 16'(count_d);

  always_comb begin
    rsp_d.valid     = start_i;
    rsp_d.status    = status;
    rsp_d.pop_ok    = pop_ok;
    rsp_d.occupancy = occ_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
      rsp_q   <= '0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
      rsp_q   <= rsp_d;
    end
  end

  assign rsp_ctl_o = rsp_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count beyond capacity");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (front_q == back_q))
    else $error("empty deque with pointer gap");

  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_full |-> (front_q == back_q))
    else $error("full deque with pointer gap");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("read and write issued together");

  a_pop_ok_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_q.pop_ok |-> $past(mem_re_o))
    else $error("pop result without a memory read");
`endif

endmodule

/* design/double_ended_queue_top.sv */
// top level of the fixed-capacity double-ended queue
// depends on deq_pkg, deq_ctrl and deq_mem
//
// Double-ended queue of DEPTH entries held in a single-port synchronous ram.
// An operation (push front, push back, pop front, pop back) transfers in when
// start_i is high while busy_o is low; busy_o is never raised, so one
// operation may transfer in every clock cycle. Each operation gives exactly
// one result, shown on rsp_o for the single cycle in which done_o is high,
// in the cycle after the operation transferred in; the receiver cannot stall
// it, so it must take the result in that cycle. The entry ram's read port
// registers it: a pop reads its entry at the transfer edge and the
// registered read data forms popped_value. Every operation touches at most
// one entry, and pointers and count update at the same edge, so a pop that
// follows a push to the same slot already sees the written value. A push on
// a full deque answers status full, a pop on an empty deque status empty;
// neither changes the contents, and popped_value is zero except for a
// successful pop. Pushed values keep their low DATA_WIDTH bits. The ram has
// no reset or clearing pass; reset clears pointers, count and the result.
module double_ended_queue_top #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  deq_pkg::deq_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output deq_pkg::deq_rsp_t rsp_o
);
  import deq_pkg::*;

  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // ram request from the pointer logic
  logic                  mem_we;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;
  deq_rsp_ctl_t          rsp_ctl;
  logic [63:0]           rdata_ext;

  // every operation completes in a fixed pipeline, no stall needed
  assign busy_o = 1'b0;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .rsp_ctl_o   (rsp_ctl)
  );

  deq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // popped entry widened then cut to the 32-bit result field
  assign rdata_ext = 64'(mem_rdata);

  // result transfer: in the cycle after the operation
  assign done_o = rsp_ctl.valid;

  always_comb begin
    rsp_o.status       = rsp_ctl.status;
    rsp_o.popped_value = rsp_ctl.pop_ok ? signed'(rdata_ext[VALUE_W-1:0]) : '0;
    rsp_o.occupancy    = rsp_ctl.occupancy;
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the double-ended queue top level
// depends on deq_pkg and double_ended_queue_top, with its deq_ctrl and deq_mem
module tb_top;
  import deq_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned RANDOM_OPS  = 550;
  localparam int unsigned CYCLE_LIMIT = 50000;
  localparam int unsigned DRAIN_WAIT  = 4;
  // pushed values keep only their low DATA_WIDTH bits
  localparam logic [VALUE_W-1:0] STORE_MASK = (DATA_WIDTH_DEF >= VALUE_W) ?
      {VALUE_W{1'b1}} : {VALUE_W{1'b1}} >> (VALUE_W - DATA_WIDTH_DEF);

  logic     clk    = 1'b0;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  deq_req_t req    = '0;
  logic     busy;
  logic     done;
  deq_rsp_t rsp;

  double_ended_queue_top uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start_i (start),
    .req_i   (req),
    .busy_o  (busy),
    .done_o  (done),
    .rsp_o   (rsp)
  );

  // operations waiting to be transferred in, and results still owed by the block
  deq_req_t op_backlog[$];
  deq_rsp_t owed_results[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // shadow deque: circular store, front index, index past the back, entry count
  logic [VALUE_W-1:0] slot_mem [DEPTH];
  int unsigned        head_idx = 0;
  int unsigned        tail_idx = 0;
  int unsigned        held     = 0;

  // entry count as the stimulus generator sees it, used to shape fill and drain runs
  int unsigned gen_held = 0;

  // sender burst shaping
  int unsigned burst_left = 20;
  int unsigned gap_left   = 0;

  // -------------------------------------------------------------------------
  // clock and reset
  // -------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // -------------------------------------------------------------------------
  // expected result of one operation; updates the shadow deque
  // -------------------------------------------------------------------------
  function automatic deq_rsp_t deque_step(input deq_req_t op);
    deq_rsp_t r;
    r.status       = STATUS_DONE;
    r.popped_value = '0;
    case (op.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (held >= DEPTH) begin
          // full: refused, contents untouched
          r.status = STATUS_FULL;
        end else if (op.func == FUNC_PUSH_FRONT) begin
          head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
          slot_mem[head_idx] = op.value & STORE_MASK;
          held++;
        end else begin
          slot_mem[tail_idx] = op.value & STORE_MASK;
          tail_idx = (tail_idx + 1 >= DEPTH) ? 0 : tail_idx + 1;
          held++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (held == 0) begin
          // empty: nothing to return
          r.status = STATUS_EMPTY;
        end else if (op.func == FUNC_POP_FRONT) begin
          r.popped_value = slot_mem[head_idx];
          head_idx = (head_idx + 1 >= DEPTH) ? 0 : head_idx + 1;
          held--;
        end else begin
          tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
          r.popped_value = slot_mem[tail_idx];
          held--;
        end
      end
    endcase
    r.occupancy = held[OCC_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // -------------------------------------------------------------------------
  // stimulus generation
  // -------------------------------------------------------------------------
  task automatic queue_op(input deq_func_e f, input logic signed [VALUE_W-1:0] v);
    deq_req_t op;
    op.func  = f;
    op.value = v;
    op_backlog.insert(op_backlog.size(), op);
    if (f == FUNC_PUSH_FRONT || f == FUNC_PUSH_BACK) begin
      if (gen_held < DEPTH) gen_held++;
    end else if (gen_held > 0) begin
      gen_held--;
    end
  endtask

  // mostly uniform values, with the extremes turning up now and then
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(VALUE_W-1){1'b0}}};
      3:       return {1'b0, {(VALUE_W-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  function automatic deq_func_e pick_push();
    return ($urandom_range(0, 1) != 0) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
  endfunction

  function automatic deq_func_e pick_pop();
    return ($urandom_range(0, 1) != 0) ? FUNC_POP_BACK : FUNC_POP_FRONT;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned run_len;

    // directed: pops on an empty deque, extreme values, both ends, pointer wrap
    queue_op(FUNC_POP_FRONT, '0);
    queue_op(FUNC_POP_BACK, 32'sh1234_5678);
    queue_op(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF);   // front wraps below index zero
    queue_op(FUNC_PUSH_BACK, 32'sh8000_0000);
    queue_op(FUNC_PUSH_FRONT, 32'sh0000_0000);
    queue_op(FUNC_PUSH_BACK, 32'shFFFF_FFFF);
    queue_op(FUNC_POP_BACK, '0);
    queue_op(FUNC_POP_FRONT, '0);
    queue_op(FUNC_POP_FRONT, '0);
    queue_op(FUNC_POP_FRONT, '0);
    queue_op(FUNC_POP_FRONT, '0);                // empty again
    queue_op(FUNC_PUSH_BACK, 32'sh5555_5555);
    queue_op(FUNC_POP_BACK, '1);
    queue_op(FUNC_PUSH_FRONT, 32'shAAAA_AAAA);
    queue_op(FUNC_POP_BACK, '0);                 // pops the other end's push
    queue_op(FUNC_POP_BACK, '0);
    queue_op(FUNC_PUSH_BACK, 32'sh0000_0001);
    queue_op(FUNC_PUSH_FRONT, 32'sh0000_0002);
    queue_op(FUNC_POP_FRONT, '0);
    queue_op(FUNC_POP_FRONT, '0);

    // random: fill runs to full and beyond, drain runs to empty and beyond, mixed runs
    phase = 0;
    while (op_backlog.size() < RANDOM_OPS) begin
      case ((phase < 2) ? phase : $urandom_range(0, 3))
        0: begin
          while (gen_held < DEPTH) queue_op(pick_push(), pick_value());
          run_len = $urandom_range(1, 4);
          repeat (run_len) queue_op(pick_push(), pick_value());
        end
        1: begin
          while (gen_held > 0) queue_op(pick_pop(), pick_value());
          run_len = $urandom_range(1, 4);
          repeat (run_len) queue_op(pick_pop(), pick_value());
        end
        default: begin
          run_len = $urandom_range(10, 60);
          repeat (run_len) queue_op(deq_func_e'($urandom_range(0, 3)), pick_value());
        end
      endcase
      phase++;
    end
  end

  // -------------------------------------------------------------------------
  // driver: presents the backlog in bursts separated by random gaps
  // -------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      // transfer in at this edge: predict its result and retire it
      if (start && !busy) begin
        owed_results.insert(owed_results.size(), deque_step(op_backlog[0]));
        op_backlog.delete(0);
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // gap of zero keeps the sender running flat out
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 40);
        end
      end

      if (start && busy) begin
        // held off: keep the same operation on the bus
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (op_backlog.size() > 0) begin
        start <= 1'b1;
        req   <= op_backlog[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // monitor: each result strobe is checked against the oldest prediction
  // -------------------------------------------------------------------------
  deq_rsp_t want;

  always @(posedge clk) begin
    if (rst_n && done) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: status %0d value %h occ %0d",
                                  rsp.status, rsp.popped_value, rsp.occupancy));
      end else begin
        want = owed_results[0];
        owed_results.delete(0);
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", rsp.status, want.status));
        if (rsp.popped_value !== want.popped_value)
          report_mismatch($sformatf("popped value %h, predicted %h",
                                    rsp.popped_value, want.popped_value));
        if (rsp.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, predicted %0d",
                                    rsp.occupancy, want.occupancy));
      end
    end
  end

  // -------------------------------------------------------------------------
  // watchdog
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timed out with %0d operations and %0d results outstanding",
               $time, op_backlog.size(), owed_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // end of run: every transfer made, every result back, then a short settle
  // -------------------------------------------------------------------------
  initial begin
    @(posedge rst_n);
    @(posedge clk);
    while (op_backlog.size() != 0 || start || owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (owed_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
